### src/bpc_pkg.sv
// ----------------------------------------------------------------------------
// Pressure compensation package
// Shared types, register indexes, reset values and arithmetic helpers for the
// pressure compensation pipeline.
// ----------------------------------------------------------------------------
package bpc_pkg;

    localparam int NUM_STAGES = 7;

    typedef enum logic [7:0] {
        REG_SENS_BASE        = 8'd0,
        REG_OFFSET_BASE      = 8'd1,
        REG_SENS_TEMP_GAIN   = 8'd2,
        REG_OFFSET_TEMP_GAIN = 8'd3,
        REG_REF_TEMP_COUNT   = 8'd4,
        REG_TEMP_SCALE       = 8'd5,
        REG_PRESSURE_BIAS    = 8'd6,
        REG_CURVE_PARAMS     = 8'd7
    } t_reg_idx;

    typedef struct packed {
        logic [15:0] sens_base;
        logic [15:0] offset_base;
        logic [15:0] sens_temp_gain;
        logic [15:0] offset_temp_gain;
        logic [15:0] ref_temp_count;
        logic [15:0] temp_scale;
        logic [15:0] pressure_bias;
        logic [7:0]  temp_shift;
        logic [7:0]  curve_shift;
        logic [7:0]  neg_gain;
        logic [7:0]  pos_gain;
    } t_cfg;

    localparam logic [15:0] RST_SENS_BASE        = 16'd29908;
    localparam logic [15:0] RST_OFFSET_BASE      = 16'd3724;
    localparam logic [15:0] RST_SENS_TEMP_GAIN   = 16'd312;
    localparam logic [15:0] RST_OFFSET_TEMP_GAIN = 16'd441;
    localparam logic [15:0] RST_REF_TEMP_COUNT   = 16'd9191;
    localparam logic [15:0] RST_TEMP_SCALE       = 16'd3990;
    localparam logic [15:0] RST_PRESSURE_BIAS    = 16'd2500;
    localparam logic [31:0] RST_CURVE_PARAMS     = 32'd151258113;

    localparam logic signed [31:0] OFFSET_GAIN_BIAS = 32'sd1024;
    localparam logic signed [16:0] PRESSURE_ZERO    = 17'sd7168;
    localparam logic signed [31:0] TEMP_BASE        = 32'sd250;
    localparam logic [7:0]         SHIFT_SQUARE     = 8'd14;
    localparam logic [7:0]         SHIFT_OFFSET     = 8'd14;
    localparam logic [7:0]         SHIFT_SENS       = 8'd10;
    localparam logic [7:0]         SHIFT_PRESSURE   = 8'd14;
    localparam logic [7:0]         SHIFT_SCALED     = 8'd5;
    localparam logic [7:0]         SHIFT_TEMP       = 8'd16;

    function automatic logic signed [31:0] asr32(input logic signed [31:0] x,
                                                 input logic [7:0] n);
        logic [4:0] sh;
        sh = (n > 8'd31) ? 5'd31 : n[4:0];
        return x >>> sh;
    endfunction

    function automatic logic signed [31:0] zext16(input logic [15:0] v);
        return signed'({16'd0, v});
    endfunction

endpackage

### src/bpc_regs.sv
// ----------------------------------------------------------------------------
// Calibration register file
// Holds the calibration coefficients and packed curve bytes, written through
// the configuration channel one word at a time.
// ----------------------------------------------------------------------------
module bpc_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_valid,
    input  logic [7:0]    i_cfg_index,
    input  logic [31:0]   i_cfg_data,
    output logic          o_cfg_ready,
    output bpc_pkg::t_cfg o_cfg
);
    import bpc_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_SENS_BASE:        n_cfg.sens_base        = i_cfg_data[15:0];
                REG_OFFSET_BASE:      n_cfg.offset_base      = i_cfg_data[15:0];
                REG_SENS_TEMP_GAIN:   n_cfg.sens_temp_gain   = i_cfg_data[15:0];
                REG_OFFSET_TEMP_GAIN: n_cfg.offset_temp_gain = i_cfg_data[15:0];
                REG_REF_TEMP_COUNT:   n_cfg.ref_temp_count   = i_cfg_data[15:0];
                REG_TEMP_SCALE:       n_cfg.temp_scale       = i_cfg_data[15:0];
                REG_PRESSURE_BIAS:    n_cfg.pressure_bias    = i_cfg_data[15:0];
                REG_CURVE_PARAMS: begin
                    n_cfg.pos_gain    = i_cfg_data[7:0];
                    n_cfg.neg_gain    = i_cfg_data[15:8];
                    n_cfg.curve_shift = i_cfg_data[23:16];
                    n_cfg.temp_shift  = i_cfg_data[31:24];
                end
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sens_base        <= RST_SENS_BASE;
            r_cfg.offset_base      <= RST_OFFSET_BASE;
            r_cfg.sens_temp_gain   <= RST_SENS_TEMP_GAIN;
            r_cfg.offset_temp_gain <= RST_OFFSET_TEMP_GAIN;
            r_cfg.ref_temp_count   <= RST_REF_TEMP_COUNT;
            r_cfg.temp_scale       <= RST_TEMP_SCALE;
            r_cfg.pressure_bias    <= RST_PRESSURE_BIAS;
            r_cfg.pos_gain         <= RST_CURVE_PARAMS[7:0];
            r_cfg.neg_gain         <= RST_CURVE_PARAMS[15:8];
            r_cfg.curve_shift      <= RST_CURVE_PARAMS[23:16];
            r_cfg.temp_shift       <= RST_CURVE_PARAMS[31:24];
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

### src/bpc_ctrl.sv
// ----------------------------------------------------------------------------
// Pipeline flow control
// Tracks a valid bit per stage and derives per-stage load enables so that
// bubbles are squeezed out and a stall at the output loses no word.
// ----------------------------------------------------------------------------
module bpc_ctrl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic                            i_ready,
    output logic                            o_ready,
    output logic                            o_valid,
    output logic [bpc_pkg::NUM_STAGES-1:0]  o_en
);
    import bpc_pkg::*;

    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] n_vld;
    logic [NUM_STAGES-1:0] en;

    always_comb begin
        en[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || i_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    always_comb begin
        n_vld = r_vld;
        if (en[0]) begin
            n_vld[0] = i_valid;
        end
        for (int k = 1; k < NUM_STAGES; k++) begin
            if (en[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_vld[NUM_STAGES-1];
    assign o_en    = en;

endmodule

### src/bpc_datapath.sv
// ----------------------------------------------------------------------------
// Compensation datapath
// Seven register stages: temperature difference and square, curvature term,
// corrected difference with its three gain products, offset and sensitivity,
// pressure product, scaling by ten, and the final sums.
// ----------------------------------------------------------------------------
module bpc_datapath (
    input  logic                           i_clk,
    input  logic [bpc_pkg::NUM_STAGES-1:0] i_en,
    input  bpc_pkg::t_cfg                  i_cfg,
    input  logic [15:0]                    i_raw_pressure,
    input  logic [15:0]                    i_raw_temperature,
    output logic signed [31:0]             o_pressure_tenths_hpa,
    output logic signed [31:0]             o_temperature_tenths_c
);
    import bpc_pkg::*;

    logic signed [16:0] dut0;
    logic signed [33:0] sq_full;
    logic signed [31:0] sq;
    logic signed [31:0] gain;
    logic signed [31:0] dut_ext;
    logic signed [31:0] dut2;
    logic signed [31:0] x;

    logic signed [16:0] r1_dut;
    logic signed [31:0] r1_sq_prod;
    logic [15:0]        r1_rp;

    logic signed [16:0] r2_dut;
    logic signed [31:0] r2_curve;
    logic [15:0]        r2_rp;

    logic signed [31:0] r3_m_off;
    logic signed [31:0] r3_m_sens;
    logic signed [31:0] r3_m_temp;
    logic signed [31:0] r3_dsh;
    logic [15:0]        r3_rp;

    logic signed [31:0] r4_off;
    logic signed [31:0] r4_sens;
    logic signed [31:0] r4_t;
    logic signed [16:0] r4_rpo;

    logic signed [31:0] r5_m;
    logic signed [31:0] r5_off;
    logic signed [31:0] r5_t;

    logic signed [31:0] r6_x10;
    logic signed [31:0] r6_t;

    logic signed [31:0] r7_p;
    logic signed [31:0] r7_t;

    assign dut0    = signed'({1'b0, i_raw_temperature}) - signed'({1'b0, i_cfg.ref_temp_count});
    assign sq_full = dut0 * dut0;

    assign sq   = asr32(r1_sq_prod, SHIFT_SQUARE);
    assign gain = r1_dut[16] ? signed'({24'd0, i_cfg.neg_gain})
                             : signed'({24'd0, i_cfg.pos_gain});

    assign dut_ext = 32'(r2_dut);
    assign dut2    = dut_ext - asr32(r2_curve, i_cfg.curve_shift);

    assign x = asr32(r5_m, SHIFT_PRESSURE) - r5_off;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r1_dut     <= dut0;
            r1_sq_prod <= sq_full[31:0];
            r1_rp      <= i_raw_pressure;
        end
        if (i_en[1]) begin
            r2_dut   <= r1_dut;
            r2_curve <= sq * gain;
            r2_rp    <= r1_rp;
        end
        if (i_en[2]) begin
            r3_m_off  <= (zext16(i_cfg.offset_temp_gain) - OFFSET_GAIN_BIAS) * dut2;
            r3_m_sens <= zext16(i_cfg.sens_temp_gain) * dut2;
            r3_m_temp <= dut2 * zext16(i_cfg.temp_scale);
            r3_dsh    <= asr32(dut2, i_cfg.temp_shift);
            r3_rp     <= r2_rp;
        end
        if (i_en[3]) begin
            r4_off  <= (zext16(i_cfg.offset_base) + asr32(r3_m_off, SHIFT_OFFSET)) <<< 2;
            r4_sens <= zext16(i_cfg.sens_base) + asr32(r3_m_sens, SHIFT_SENS);
            r4_t    <= TEMP_BASE + asr32(r3_m_temp, SHIFT_TEMP) - r3_dsh;
            r4_rpo  <= signed'({1'b0, r3_rp}) - PRESSURE_ZERO;
        end
        if (i_en[4]) begin
            r5_m   <= r4_sens * 32'(r4_rpo);
            r5_off <= r4_off;
            r5_t   <= r4_t;
        end
        if (i_en[5]) begin
            r6_x10 <= (x <<< 3) + (x <<< 1);
            r6_t   <= r5_t;
        end
        if (i_en[6]) begin
            r7_p <= asr32(r6_x10, SHIFT_SCALED) + zext16(i_cfg.pressure_bias);
            r7_t <= r6_t;
        end
    end

    assign o_pressure_tenths_hpa  = r7_p;
    assign o_temperature_tenths_c = r7_t;

endmodule

### src/barometric_pressure_compensation_top.sv
// ----------------------------------------------------------------------------
// Barometric pressure compensation
// Flow: an accepted word passes through the datapath stages in order to its result word.
// Throughput: one word per cycle while the output is not stalled; each stage
// holds one word and loads when it is empty or the stage after it moves on.
// Reset: synchronous, active low; clears all stage valid bits and returns
// the calibration registers to their default coefficients.
// ----------------------------------------------------------------------------
module barometric_pressure_compensation_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [15:0]        i_raw_pressure,
    input  logic [15:0]        i_raw_temperature,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_pressure_tenths_hpa,
    output logic signed [31:0] o_temperature_tenths_c,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [7:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);
    import bpc_pkg::*;

    t_cfg                  cfg;
    logic [NUM_STAGES-1:0] en;

    bpc_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (cfg)
    );

    bpc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_ready (i_ready),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .o_en    (en)
    );

    bpc_datapath u_datapath (
        .i_clk                  (i_clk),
        .i_en                   (en),
        .i_cfg                  (cfg),
        .i_raw_pressure         (i_raw_pressure),
        .i_raw_temperature      (i_raw_temperature),
        .o_pressure_tenths_hpa  (o_pressure_tenths_hpa),
        .o_temperature_tenths_c (o_temperature_tenths_c)
    );

endmodule

### src/bpc_checker.sv
// ----------------------------------------------------------------------------
// Pressure compensation port checker
// Watches the ports of the top level for flow control and latency slips.
// ----------------------------------------------------------------------------
module bpc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_ready,
    input logic               o_valid,
    input logic               i_ready,
    input logic signed [31:0] o_pressure_tenths_hpa,
    input logic signed [31:0] o_temperature_tenths_c
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_pressure_tenths_hpa)
                                && $stable(o_temperature_tenths_c))
        else $error("Result word changed or vanished while stalled.");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("Input stalled while the output register is empty.");

    a_flow_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ready |-> o_ready)
        else $error("Input stalled while the output is being drained.");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) ##1 i_ready ##1 i_ready ##1 i_ready ##1 i_ready
        ##1 i_ready ##1 i_ready |=> o_valid)
        else $error("Accepted word did not reach the output in seven cycles.");

endmodule

bind barometric_pressure_compensation_top bpc_checker u_bpc_checker (.*);

### tb/testbench.sv
// ----------------------------------------------------------------------------
// Barometric pressure compensation testbench
// Sends raw pressure and temperature words and checks each compensated result
// word against an in-bench calculation built from the current calibration set.
// The run covers directed extremes, large shift bytes and unused register
// indexes, a long output stall, and random words over many calibrations.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bpc_pkg::*;

    localparam int          NUM_CAL_REGS      = 8;
    localparam int          PIPE_LATENCY      = 7;
    localparam int          SAMPLES_PER_PHASE = 150;
    localparam int          RANDOM_PHASES     = 12;
    localparam logic [7:0]  FIRST_UNUSED_REG  = 8'd8;
    localparam logic [7:0]  LAST_REG_CODE     = 8'hFF;
    localparam logic [31:0] GAIN_ZERO         = 32'd1024;
    localparam logic [31:0] COUNT_ZERO        = 32'd7168;
    localparam logic [31:0] TEMP_TENTHS_BASE  = 32'd250;
    localparam logic [31:0] OFFSET_SCALE      = 32'd4;
    localparam logic [31:0] PRESSURE_SCALE    = 32'd10;
    localparam logic [31:0] SQUARE_SHIFT      = 32'd14;
    localparam logic [31:0] OFFSET_SHIFT      = 32'd14;
    localparam logic [31:0] SENS_SHIFT        = 32'd10;
    localparam logic [31:0] SPAN_SHIFT        = 32'd14;
    localparam logic [31:0] TENTHS_SHIFT      = 32'd5;
    localparam logic [31:0] TEMP_SHIFT        = 32'd16;

    typedef struct packed {
        logic [31:0] pressure;
        logic [31:0] temperature;
    } t_reading;

    logic               i_clk;
    logic               i_rst_n                = 1'b0;
    logic               i_valid                = 1'b0;
    logic               o_ready;
    logic [15:0]        i_raw_pressure         = '0;
    logic [15:0]        i_raw_temperature      = '0;
    logic               o_valid;
    logic               i_ready                = 1'b0;
    logic signed [31:0] o_pressure_tenths_hpa;
    logic signed [31:0] o_temperature_tenths_c;
    logic               i_cfg_valid            = 1'b0;
    logic               o_cfg_ready;
    logic [7:0]         i_cfg_index            = '0;
    logic [31:0]        i_cfg_data             = '0;

    logic [31:0] cal_regs [NUM_CAL_REGS];
    t_reading    pending_readings [$];
    bit          steady          = 1'b0;
    int          hold_request    = 0;
    int          error_count     = 0;
    int          samples_sent    = 0;
    int          readings_checked = 0;
    int          settings_used   = 0;

    barometric_pressure_compensation_top DUT (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_valid                (i_valid),
        .o_ready                (o_ready),
        .i_raw_pressure         (i_raw_pressure),
        .i_raw_temperature      (i_raw_temperature),
        .o_valid                (o_valid),
        .i_ready                (i_ready),
        .o_pressure_tenths_hpa  (o_pressure_tenths_hpa),
        .o_temperature_tenths_c (o_temperature_tenths_c),
        .i_cfg_valid            (i_cfg_valid),
        .o_cfg_ready            (o_cfg_ready),
        .i_cfg_index            (i_cfg_index),
        .i_cfg_data             (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic [31:0] sra32(input logic [31:0] value, input logic [31:0] amount);
        logic signed [31:0] word;
        logic [31:0]        sh;
        sh   = (amount > 32'd31) ? 32'd31 : amount;
        word = value;
        return word >>> sh;
    endfunction

    function automatic logic [31:0] default_cal(input t_reg_idx idx);
        case (idx)
            REG_SENS_BASE:        return {16'd0, RST_SENS_BASE};
            REG_OFFSET_BASE:      return {16'd0, RST_OFFSET_BASE};
            REG_SENS_TEMP_GAIN:   return {16'd0, RST_SENS_TEMP_GAIN};
            REG_OFFSET_TEMP_GAIN: return {16'd0, RST_OFFSET_TEMP_GAIN};
            REG_REF_TEMP_COUNT:   return {16'd0, RST_REF_TEMP_COUNT};
            REG_TEMP_SCALE:       return {16'd0, RST_TEMP_SCALE};
            REG_PRESSURE_BIAS:    return {16'd0, RST_PRESSURE_BIAS};
            default:              return RST_CURVE_PARAMS;
        endcase
    endfunction

    function automatic t_reading compensate(input logic [15:0] raw_p, input logic [15:0] raw_t);
        logic [31:0] curve;
        logic [31:0] temp_delta;
        logic [31:0] square;
        logic [31:0] curve_gain;
        logic [31:0] offset;
        logic [31:0] sensitivity;
        logic [31:0] span;
        t_reading    reading;
        curve       = cal_regs[REG_CURVE_PARAMS];
        temp_delta  = {16'd0, raw_t} - cal_regs[REG_REF_TEMP_COUNT];
        square      = sra32(temp_delta * temp_delta, SQUARE_SHIFT);
        curve_gain  = temp_delta[31] ? {24'd0, curve[15:8]} : {24'd0, curve[7:0]};
        temp_delta  = temp_delta - sra32(square * curve_gain, {24'd0, curve[23:16]});
        offset      = (cal_regs[REG_OFFSET_BASE]
                      + sra32((cal_regs[REG_OFFSET_TEMP_GAIN] - GAIN_ZERO) * temp_delta,
                              OFFSET_SHIFT)) * OFFSET_SCALE;
        sensitivity = cal_regs[REG_SENS_BASE]
                      + sra32(cal_regs[REG_SENS_TEMP_GAIN] * temp_delta, SENS_SHIFT);
        span        = sra32(sensitivity * ({16'd0, raw_p} - COUNT_ZERO), SPAN_SHIFT) - offset;
        reading.pressure    = sra32(span * PRESSURE_SCALE, TENTHS_SHIFT)
                              + cal_regs[REG_PRESSURE_BIAS];
        reading.temperature = TEMP_TENTHS_BASE
                              + sra32(temp_delta * cal_regs[REG_TEMP_SCALE], TEMP_SHIFT)
                              - sra32(temp_delta, {24'd0, curve[31:24]});
        return reading;
    endfunction

    function automatic logic [31:0] random_cal_value(input t_reg_idx idx);
        logic [31:0] value;
        int          pick;
        pick  = $urandom_range(0, 3);
        value = $urandom;
        if (idx == REG_CURVE_PARAMS) begin
            if (pick == 1) begin
                value = $urandom_range(0, 1) ? '1 : '0;
            end else if (pick > 1) begin
                value[31:24] = 8'($urandom_range(0, 31));
                value[23:16] = 8'($urandom_range(0, 31));
            end
        end else begin
            if (pick == 1) begin
                value[15:0] = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            end else if (pick > 1) begin
                value[15:0] = 16'(default_cal(idx) + $urandom_range(0, 64) - 32);
            end
        end
        return value;
    endfunction

    task automatic send_sample(input logic [15:0] raw_p, input logic [15:0] raw_t);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid           <= 1'b1;
        i_raw_pressure    <= raw_p;
        i_raw_temperature <= raw_t;
        do @(posedge i_clk); while (!o_ready);
        pending_readings.push_back(compensate(raw_p, raw_t));
        samples_sent++;
    endtask

    task automatic drain_pipeline();
        i_valid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge i_clk);
        repeat (PIPE_LATENCY + 3) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [7:0] index, input logic [31:0] data);
        drain_pipeline();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (index < NUM_CAL_REGS) begin
            cal_regs[index] = (index == REG_CURVE_PARAMS) ? data : {16'd0, data[15:0]};
        end
    endtask

    task automatic load_calibration(input bit use_defaults, input logic [31:0] fill);
        for (int r = 0; r < NUM_CAL_REGS; r++) begin
            cfg_write(r[7:0], use_defaults ? default_cal(t_reg_idx'(r)) : fill);
        end
        settings_used++;
    endtask

    task automatic check_reading(input logic [31:0] pressure, input logic [31:0] temperature);
        t_reading wanted;
        if (pending_readings.size() == 0) begin
            $error("result word arrived with no sample outstanding");
            error_count++;
        end else begin
            wanted = pending_readings.pop_front();
            if (pressure !== wanted.pressure) begin
                $error("pressure_tenths_hpa: expected %0d, got %0d",
                       $signed(wanted.pressure), $signed(pressure));
                error_count++;
            end
            if (temperature !== wanted.temperature) begin
                $error("temperature_tenths_c: expected %0d, got %0d",
                       $signed(wanted.temperature), $signed(temperature));
                error_count++;
            end
            readings_checked++;
        end
    endtask

    initial begin : result_monitor
        int stall;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 3);
            if (hold_request > 0) begin
                stall        = hold_request;
                hold_request = 0;
            end
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid && hold_request == 0);
            if (o_valid) begin
                check_reading(o_pressure_tenths_hpa, o_temperature_tenths_c);
            end
        end
    end

    task automatic check_default_calibration();
        send_sample(16'd0, 16'd0);
        send_sample(16'hFFFF, 16'hFFFF);
        send_sample(COUNT_ZERO[15:0], RST_REF_TEMP_COUNT);
        send_sample(16'd30000, RST_REF_TEMP_COUNT - 16'd1);
        send_sample(16'd30000, RST_REF_TEMP_COUNT + 16'd1);
        send_sample(16'hFFFF, 16'd0);
        send_sample(16'd0, 16'hFFFF);
    endtask

    task automatic check_register_extremes();
        load_calibration(1'b0, 32'h0000_0000);
        send_sample(16'd0, 16'd0);
        send_sample(16'hFFFF, 16'hFFFF);
        send_sample(COUNT_ZERO[15:0], 16'h8000);
        load_calibration(1'b0, 32'hFFFF_FFFF);
        send_sample(16'hFFFF, 16'd0);
        send_sample(16'd0, 16'hFFFF);
        send_sample(16'h5A5A, 16'hA5A5);
        load_calibration(1'b1, '0);
        // Shift bytes beyond 31 must behave as a shift of 31.
        cfg_write(REG_CURVE_PARAMS, {8'd255, 8'd40, 8'hFF, 8'hFF});
        send_sample(16'd40000, 16'd0);
        send_sample(16'd40000, 16'hFFFF);
        cfg_write(REG_CURVE_PARAMS, {8'd31, 8'd0, 8'h80, 8'h7F});
        send_sample(16'd20000, 16'd100);
        send_sample(16'd20000, 16'd60000);
        settings_used += 2;
    endtask

    task automatic check_unknown_index();
        load_calibration(1'b1, '0);
        cfg_write(FIRST_UNUSED_REG, $urandom);
        cfg_write(LAST_REG_CODE, $urandom);
        cfg_write(8'($urandom_range(FIRST_UNUSED_REG, LAST_REG_CODE)), $urandom);
        send_sample(16'd25000, 16'd9000);
        send_sample(16'd50000, 16'd12000);
    endtask

    task automatic check_output_backpressure();
        drain_pipeline();
        steady       = 1'b1;
        hold_request = 80;
        repeat (2) @(posedge i_clk);
        for (int n = 0; n < 30; n++) begin
            send_sample(16'($urandom), 16'($urandom));
        end
        drain_pipeline();
        steady = 1'b0;
    endtask

    task automatic check_random_samples();
        logic [15:0] raw_t;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            for (int r = 0; r < NUM_CAL_REGS; r++) begin
                cfg_write(r[7:0], random_cal_value(t_reg_idx'(r)));
            end
            settings_used++;
            steady = (phase % 3 == 2);
            for (int n = 0; n < SAMPLES_PER_PHASE; n++) begin
                raw_t = 16'($urandom);
                if ($urandom_range(0, 3) == 0) begin
                    raw_t = 16'(cal_regs[REG_REF_TEMP_COUNT][15:0]
                                + $urandom_range(0, 512) - 256);
                end
                send_sample(16'($urandom), raw_t);
            end
            drain_pipeline();
            steady = 1'b0;
        end
    endtask

    initial begin
        for (int r = 0; r < NUM_CAL_REGS; r++) begin
            cal_regs[r] = default_cal(t_reg_idx'(r));
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        settings_used = 1;
        check_default_calibration();
        check_register_extremes();
        check_unknown_index();
        check_output_backpressure();
        check_random_samples();
        drain_pipeline();
        $display("Run covered %0d sample words over %0d calibration sets, a long output stall,",
                 samples_sent, settings_used);
        $display("large shift bytes and unused register indexes; %0d result words compared.",
                 readings_checked);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### filelist.f
src/bpc_pkg.sv
src/bpc_regs.sv
src/bpc_ctrl.sv
src/bpc_datapath.sv
src/barometric_pressure_compensation_top.sv
src/bpc_checker.sv
tb/testbench.sv
